@@ design/scut_pkg.sv @@
// Shared constants, register codes and inter-module request types for the
// silence cutter. No dependencies.
package scut_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int FIFO_DEPTH = 8192;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FILL_W     = PTR_W + 1;

  localparam int LOOKAHEAD  = 5512;
  localparam int FADE_LEN   = 1378;
  localparam int FADE_W     = 11;

  localparam int TP_W       = 8;
  localparam int LEARN_W    = 20;
  localparam int HOLD_W     = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [TP_W-1:0]    TP_RST    = TP_W'(115);
  localparam logic [LEARN_W-1:0] LEARN_RST = LEARN_W'(441000);
  localparam logic [HOLD_W-1:0]  HOLD_RST  = HOLD_W'(11024);

  localparam int PCT_SCALE  = 100;
  localparam int NOISE_W    = SAMPLE_W - 1;
  localparam int PROD_W     = NOISE_W + TP_W;

  localparam int NUM_W      = 28;
  localparam int QMAG_W     = 26;
  localparam int RECIP_SH   = QMAG_W;
  localparam int RECIP_W    = RECIP_SH + 1;
  localparam int QP_W       = QMAG_W + RECIP_W;
  localparam int Q_W        = SAMPLE_W + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / FADE_LEN);
  localparam logic signed [NUM_W-1:0] FADE_LEN_S = NUM_W'(FADE_LEN);

  localparam int OQ_DEPTH   = 8;
  localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W   = OQ_PTR_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_LEARN     = 2'd1,
    REG_HOLD      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                       we;
    logic [PTR_W-1:0]           waddr;
    logic signed [SAMPLE_W-1:0] wdata;
    logic                       re;
    logic [PTR_W-1:0]           raddr;
  } mem_req_t;

  typedef struct packed {
    logic                       valid;
    logic                       fwd;
    logic                       arm;
    logic [FADE_W-1:0]          fcnt;
    logic signed [SAMPLE_W-1:0] sample;
  } fade_req_t;

endpackage

@@ design/scut_fifo_mem.sv @@
// Lookahead sample buffer: one write and one registered read per cycle.
// Depends on scut_pkg.
module scut_fifo_mem (
  input  logic                                clk,
  input  scut_pkg::mem_req_t                  req,
  output logic signed [scut_pkg::SAMPLE_W-1:0] rdata
);

  logic signed [scut_pkg::SAMPLE_W-1:0] mem_q [scut_pkg::FIFO_DEPTH];
  logic signed [scut_pkg::SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_q[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem_q[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/scut_ctrl.sv @@
// Front end: config registers, noise learning, loudness compare and the
// gate decisions that drive the sample buffer and the fade pipeline. Depends on scut_pkg.
module scut_ctrl (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic signed [scut_pkg::SAMPLE_W-1:0]  in_tdata,
  input  logic                                  cfg_we,
  input  logic [scut_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [scut_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  credit_full,
  input  logic                                  fade_busy,
  output scut_pkg::mem_req_t                    mem_req,
  output scut_pkg::fade_req_t                   fade_req
);

  logic [scut_pkg::TP_W-1:0]    tp_r;
  logic [scut_pkg::LEARN_W-1:0] learn_samples_r;
  logic [scut_pkg::HOLD_W-1:0]  hold_samples_r;

  logic signed [scut_pkg::SAMPLE_W-1:0] noise_r, noise_nxt;
  logic [scut_pkg::LEARN_W-1:0]         learn_cnt_r, learn_cnt_nxt;

  logic                                 b_valid_r;
  logic signed [scut_pkg::SAMPLE_W-1:0] b_sample_r;
  logic [scut_pkg::NOISE_W-1:0]         b_noise_r;
  logic [scut_pkg::SAMPLE_W-1:0]        b_mag;
  logic [scut_pkg::PROD_W-1:0]          b_prod, b_mag100;

  logic                                 c_valid_r;
  logic signed [scut_pkg::SAMPLE_W-1:0] c_sample_r;
  logic [scut_pkg::PROD_W-1:0]          c_prod_r, c_mag100_r;

  logic [scut_pkg::FILL_W-1:0]  fill_r, fill_nxt;
  logic [scut_pkg::PTR_W-1:0]   rd_ptr_r, wr_ptr_r;
  logic                         was_loud_r, was_loud_nxt;
  logic [scut_pkg::HOLD_W-1:0]  hold_cnt_r, hold_cnt_nxt, hold_eff;
  logic [scut_pkg::FADE_W-1:0]  fade_cnt_r, fade_cnt_nxt, fcnt_use;
  logic                         pend_r, pend_nxt;
  logic                         drop_r, drop_nxt;

  logic accept, loud, emit, pop, arm, c_hold, c_adv, c_free, b_free;

  assign accept = in_tvalid && in_tready;

  always_comb begin
    noise_nxt     = noise_r;
    learn_cnt_nxt = learn_cnt_r;
    if (accept && (learn_cnt_r < learn_samples_r)) begin
      if (in_tdata > noise_r) begin
        noise_nxt = in_tdata;
      end
      learn_cnt_nxt = learn_cnt_r + 1'b1;
    end
  end

  assign b_mag    = b_sample_r[scut_pkg::SAMPLE_W-1] ?
                    (scut_pkg::SAMPLE_W'(0) - unsigned'(b_sample_r)) : unsigned'(b_sample_r);
  assign b_prod   = scut_pkg::PROD_W'(b_noise_r) * scut_pkg::PROD_W'(tp_r);
  assign b_mag100 = scut_pkg::PROD_W'(b_mag) * scut_pkg::PROD_W'(scut_pkg::PCT_SCALE);

  assign loud = c_mag100_r > c_prod_r;

  always_comb begin
    emit         = 1'b0;
    pop          = 1'b0;
    arm          = 1'b0;
    fcnt_use     = fade_cnt_r;
    was_loud_nxt = was_loud_r;
    hold_eff     = was_loud_r ? hold_samples_r : hold_cnt_r;
    hold_cnt_nxt = hold_cnt_r;
    pend_nxt     = pend_r;
    drop_nxt     = drop_r;
    if (loud) begin
      was_loud_nxt = 1'b1;
      drop_nxt     = 1'b0;
      emit         = 1'b1;
      if (pend_r) begin
        pend_nxt = 1'b0;
        arm      = 1'b1;
        fcnt_use = scut_pkg::FADE_W'(scut_pkg::FADE_LEN);
      end
    end else begin
      was_loud_nxt = 1'b0;
      if (hold_eff != '0) begin
        drop_nxt     = 1'b0;
        emit         = 1'b1;
        hold_cnt_nxt = hold_eff - 1'b1;
      end else begin
        hold_cnt_nxt = hold_eff;
        if (fill_r >= scut_pkg::FILL_W'(scut_pkg::LOOKAHEAD)) begin
          pop = 1'b1;
          if (!drop_r) begin
            drop_nxt = 1'b1;
          end else begin
            pend_nxt = 1'b1;
            fcnt_use = '0;
          end
        end
      end
    end
    if (emit) begin
      pop = 1'b1;
    end
    fade_cnt_nxt = (emit && (fcnt_use != '0)) ? fcnt_use - 1'b1 : fcnt_use;
    fill_nxt     = pop ? fill_r : fill_r + 1'b1;
  end

  assign c_hold    = c_valid_r && emit && (credit_full || (arm && fade_busy));
  assign c_adv     = c_valid_r && !c_hold;
  assign c_free    = !c_valid_r || c_adv;
  assign b_free    = !b_valid_r || c_free;
  assign in_tready = b_free;

  assign mem_req.we    = c_adv;
  assign mem_req.waddr = wr_ptr_r;
  assign mem_req.wdata = c_sample_r;
  assign mem_req.re    = c_adv && emit;
  assign mem_req.raddr = rd_ptr_r;

  assign fade_req.valid  = c_adv && emit;
  assign fade_req.fwd    = (fill_r == '0);
  assign fade_req.arm    = arm;
  assign fade_req.fcnt   = fcnt_use;
  assign fade_req.sample = c_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tp_r            <= scut_pkg::TP_RST;
      learn_samples_r <= scut_pkg::LEARN_RST;
      hold_samples_r  <= scut_pkg::HOLD_RST;
    end else if (cfg_we) begin
      case (scut_pkg::cfg_reg_t'(cfg_idx))
        scut_pkg::REG_THRESHOLD: tp_r            <= cfg_wdata[scut_pkg::TP_W-1:0];
        scut_pkg::REG_LEARN:     learn_samples_r <= cfg_wdata[scut_pkg::LEARN_W-1:0];
        scut_pkg::REG_HOLD:      hold_samples_r  <= cfg_wdata[scut_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_r     <= '0;
      learn_cnt_r <= '0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      fill_r      <= '0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      was_loud_r  <= 1'b0;
      hold_cnt_r  <= '0;
      fade_cnt_r  <= '0;
      pend_r      <= 1'b0;
      drop_r      <= 1'b0;
    end else begin
      noise_r     <= noise_nxt;
      learn_cnt_r <= learn_cnt_nxt;
      if (b_free) begin
        b_valid_r <= accept;
      end
      if (c_free) begin
        c_valid_r <= b_valid_r;
      end
      if (c_adv) begin
        fill_r     <= fill_nxt;
        wr_ptr_r   <= wr_ptr_r + 1'b1;
        rd_ptr_r   <= pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
        was_loud_r <= was_loud_nxt;
        hold_cnt_r <= hold_cnt_nxt;
        fade_cnt_r <= fade_cnt_nxt;
        pend_r     <= pend_nxt;
        drop_r     <= drop_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_sample_r <= in_tdata;
      b_noise_r  <= noise_nxt[scut_pkg::NOISE_W-1:0];
    end
    if (c_free && b_valid_r) begin
      c_sample_r <= b_sample_r;
      c_prod_r   <= b_prod;
      c_mag100_r <= b_mag100;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= scut_pkg::FILL_W'(scut_pkg::LOOKAHEAD))
    else $error("buffer fill above lookahead");

  a_fade_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fade_cnt_r <= scut_pkg::FADE_W'(scut_pkg::FADE_LEN))
    else $error("fade count above fade length");

  a_wr_rd_gap: assert property (@(posedge clk) disable iff (!rst_n)
    c_adv |=> (wr_ptr_r - rd_ptr_r) == fill_r[scut_pkg::PTR_W-1:0])
    else $error("buffer pointers disagree with fill");

endmodule

@@ design/scut_fade.sv @@
// Crossfade pipeline: head select, linear blend and divide by fade length
// through a reciprocal multiply with one correction step. Depends on scut_pkg.
module scut_fade (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  scut_pkg::fade_req_t                   req,
  input  logic signed [scut_pkg::SAMPLE_W-1:0]  mem_rdata,
  output logic                                  busy,
  output logic                                  res_valid,
  output logic signed [scut_pkg::SAMPLE_W-1:0]  res_data
);

  logic signed [scut_pkg::SAMPLE_W-1:0] last_out_r, fade_from_r;

  logic                                 s1_valid_r, s1_fwd_r, s1_arm_r;
  logic [scut_pkg::FADE_W-1:0]          s1_fcnt_r;
  logic signed [scut_pkg::SAMPLE_W-1:0] s1_sample_r, s1_head, s1_from;
  logic signed [scut_pkg::SAMPLE_W:0]   s1_diff;

  logic                                 s2_valid_r;
  logic signed [scut_pkg::SAMPLE_W-1:0] s2_head_r;
  logic signed [scut_pkg::SAMPLE_W:0]   s2_diff_r;
  logic [scut_pkg::FADE_W-1:0]          s2_fcnt_r;
  logic signed [scut_pkg::NUM_W-1:0]    s2_prod, s2_headf;

  logic                                 s3_valid_r;
  logic signed [scut_pkg::NUM_W-1:0]    s3_prod_r, s3_headf_r, s3_num, s3_abs;

  logic                                 s4_valid_r, s4_neg_r;
  logic [scut_pkg::QMAG_W-1:0]          s4_mag_r;
  logic [scut_pkg::QP_W-1:0]            s4_qp;

  logic                                 s5_valid_r, s5_neg_r;
  logic [scut_pkg::QMAG_W-1:0]          s5_mag_r, s5_q0f;
  logic [scut_pkg::Q_W-1:0]             s5_q0_r;

  logic                                 s6_valid_r, s6_neg_r;
  logic [scut_pkg::QMAG_W-1:0]          s6_mag_r, s6_q0f_r, s6_rem;
  logic [scut_pkg::Q_W-1:0]             s6_q0_r, s6_q;

  logic                                 s7_valid_r, s7_neg_r;
  logic [scut_pkg::Q_W-1:0]             s7_q_r, s7_sq;

  assign s1_head = s1_fwd_r ? s1_sample_r : mem_rdata;
  assign s1_from = s1_arm_r ? last_out_r : fade_from_r;
  assign s1_diff = {s1_from[scut_pkg::SAMPLE_W-1], s1_from}
                 - {s1_head[scut_pkg::SAMPLE_W-1], s1_head};

  assign s2_prod  = scut_pkg::NUM_W'(s2_diff_r)
                  * scut_pkg::NUM_W'($signed({1'b0, s2_fcnt_r}));
  assign s2_headf = s2_head_r * scut_pkg::FADE_LEN_S;

  assign s3_num = s3_headf_r + s3_prod_r;
  assign s3_abs = s3_num[scut_pkg::NUM_W-1] ? -s3_num : s3_num;

  assign s4_qp  = scut_pkg::QP_W'(s4_mag_r) * scut_pkg::QP_W'(scut_pkg::RECIP);
  assign s5_q0f = scut_pkg::QMAG_W'(s5_q0_r) * scut_pkg::QMAG_W'(scut_pkg::FADE_LEN);

  assign s6_rem = s6_mag_r - s6_q0f_r;
  assign s6_q   = s6_q0_r
                + scut_pkg::Q_W'(s6_rem >= scut_pkg::QMAG_W'(scut_pkg::FADE_LEN));

  assign s7_sq    = s7_neg_r ? (scut_pkg::Q_W'(0) - s7_q_r) : s7_q_r;
  assign res_data = signed'(s7_sq[scut_pkg::SAMPLE_W-1:0]);
  assign res_valid = s7_valid_r;

  assign busy = s1_valid_r | s2_valid_r | s3_valid_r | s4_valid_r
              | s5_valid_r | s6_valid_r | s7_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      s7_valid_r  <= 1'b0;
      last_out_r  <= '0;
      fade_from_r <= '0;
    end else begin
      s1_valid_r <= req.valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
      s6_valid_r <= s5_valid_r;
      s7_valid_r <= s6_valid_r;
      if (s1_valid_r && s1_arm_r) begin
        fade_from_r <= last_out_r;
      end
      if (s7_valid_r) begin
        last_out_r <= res_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_fwd_r    <= req.fwd;
    s1_arm_r    <= req.arm;
    s1_fcnt_r   <= req.fcnt;
    s1_sample_r <= req.sample;
    s2_head_r   <= s1_head;
    s2_diff_r   <= s1_diff;
    s2_fcnt_r   <= s1_fcnt_r;
    s3_prod_r   <= s2_prod;
    s3_headf_r  <= s2_headf;
    s4_mag_r    <= s3_abs[scut_pkg::QMAG_W-1:0];
    s4_neg_r    <= s3_num[scut_pkg::NUM_W-1];
    s5_q0_r     <= s4_qp[scut_pkg::RECIP_SH +: scut_pkg::Q_W];
    s5_mag_r    <= s4_mag_r;
    s5_neg_r    <= s4_neg_r;
    s6_q0_r     <= s5_q0_r;
    s6_q0f_r    <= s5_q0f;
    s6_mag_r    <= s5_mag_r;
    s6_neg_r    <= s5_neg_r;
    s7_q_r      <= s6_q;
    s7_neg_r    <= s6_neg_r;
  end

endmodule

@@ design/scut_outq.sv @@
// Result queue between the fade pipeline and the output stream.
// Depends on scut_pkg.
module scut_outq (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  wr_en,
  input  logic signed [scut_pkg::SAMPLE_W-1:0]  wr_data,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic signed [scut_pkg::SAMPLE_W-1:0]  out_tdata
);

  logic signed [scut_pkg::SAMPLE_W-1:0] q_r [scut_pkg::OQ_DEPTH];
  logic [scut_pkg::OQ_PTR_W-1:0]        wp_r, rp_r;
  logic [scut_pkg::OQ_CNT_W-1:0]        cnt_r;
  logic                                 rd_en;

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = q_r[rp_r];
  assign rd_en      = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + scut_pkg::OQ_CNT_W'(wr_en) - scut_pkg::OQ_CNT_W'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wp_r] <= wr_data;
    end
  end

endmodule

@@ design/silence_cutter_with_crossfade.sv @@
// Silence cutter with crossfade. Throughput: one sample per cycle, except while the
// 8-entry result credit is full; a request that starts a crossfade waits for the
// fade pipeline to drain.
// Reset (rst_n low, synchronous) clears control state, counters, noise level
// and pointers and loads the register defaults; the sample buffer is not cleared.
module silence_cutter_with_crossfade (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic signed [scut_pkg::SAMPLE_W-1:0]  in_tdata,   // [15:0] sample_in
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic signed [scut_pkg::SAMPLE_W-1:0]  out_tdata,  // [15:0] sample_out
  input  logic                                  cfg_we,
  input  logic [scut_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [scut_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  scut_pkg::mem_req_t                   mem_req;
  scut_pkg::fade_req_t                  fade_req;
  logic signed [scut_pkg::SAMPLE_W-1:0] mem_rdata, res_data;
  logic                                 fade_busy, res_valid, credit_full;
  logic [scut_pkg::OQ_CNT_W-1:0]        credit_r;

  assign credit_full = (credit_r == scut_pkg::OQ_CNT_W'(scut_pkg::OQ_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_r + scut_pkg::OQ_CNT_W'(fade_req.valid)
                - scut_pkg::OQ_CNT_W'(out_tvalid && out_tready);
    end
  end

  scut_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .credit_full (credit_full),
    .fade_busy   (fade_busy),
    .mem_req     (mem_req),
    .fade_req    (fade_req)
  );

  scut_fifo_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  scut_fade u_fade (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (fade_req),
    .mem_rdata (mem_rdata),
    .busy      (fade_busy),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  scut_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (res_valid),
    .wr_data    (res_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= scut_pkg::OQ_CNT_W'(scut_pkg::OQ_DEPTH))
    else $error("result credit overflow");

  a_arm_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (fade_req.valid && fade_req.arm) |-> !fade_busy)
    else $error("crossfade armed while fade pipeline busy");

  a_res_credit: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> credit_r != '0)
    else $error("result produced without outstanding credit");

endmodule
